/* rtl/rau_pkg.sv */
package rau_pkg;

  localparam int unsigned WORD_BITS = 32;
  localparam int unsigned PROD_W    = 64;
  localparam int unsigned MAG_W     = 64;
  localparam int unsigned SUM_W     = 65;
  localparam int unsigned CNT_W     = 7;

  typedef enum logic [2:0] {
    OP_ADD = 3'd0,
    OP_SUB = 3'd1,
    OP_MUL = 3'd2,
    OP_DIV = 3'd3,
    OP_CMP = 3'd4
  } op_e;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_DIV_ZERO = 2'd1,
    ST_OVERFLOW = 2'd2
  } status_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_MUL0,
    S_MUL1,
    S_MUL2,
    S_COMB,
    S_GCD_LOAD,
    S_GCD,
    S_DIVN_LOAD,
    S_DIVN,
    S_DIVD_LOAD,
    S_DIVD,
    S_FINISH
  } state_e;

  typedef struct packed {
    logic start;
    logic [MAG_W-1:0] dividend;
    logic [MAG_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic done;
    logic [MAG_W-1:0] quotient;
    logic [MAG_W-1:0] remainder;
  } div_rsp_t;

endpackage

/* rtl/rational_arithmetic_unit.sv */
// Items that need no reduction (compare, unknown operation codes, zero denominators, division
//   by zero, zero results) skip the divider; all others reduce by Euclid's algorithm, and
//   every remainder and exact division runs in one shared 64-step restoring divider.
// Throughput: one item at a time; busy is high while an item is in flight and is low again when done_o pulses.
// Reset: rst_ni asynchronous, active low; returns the sequencer to idle, no result pending.
// The receiver cannot stall: each result shows on done_o for exactly one cycle.
module rational_arithmetic_unit import rau_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start,
  output logic                 busy,
  input  logic [2:0]           operation_i,
  input  logic signed [31:0]   a_num_i,
  input  logic [30:0]          a_den_i,
  input  logic signed [31:0]   b_num_i,
  input  logic [30:0]          b_den_i,
  output logic                 done_o,
  output logic signed [31:0]   res_num_o,
  output logic [30:0]          res_den_o,
  output logic                 is_greater_o,
  output logic                 is_equal_o,
  output logic [1:0]           status_o
);

  state_e state_q, state_d;
  logic [2:0]              op_q;
  logic signed [31:0]      an_q, bn_q;
  logic [30:0]             ad_q, bd_q;
  logic signed [PROD_W-1:0] p0_q, p1_q, p0_d, p1_d;
  logic [PROD_W-1:0]       den_q, den_d;
  logic                    neg_q, neg_d;
  logic [MAG_W-1:0]        mag_q, mag_d, u_q, u_d, v_q, v_d;
  logic                    done_q, done_d;
  logic signed [31:0]      rn_q, rn_d;
  logic [30:0]             rd_q, rd_d;
  logic                    gt_q, gt_d, eq_q, eq_d;
  logic [1:0]              st_q, st_d;
  div_req_t                dreq;
  div_rsp_t                drsp;

  logic signed [31:0]      mul_a;
  logic signed [32:0]      mul_b;
  logic signed [PROD_W:0]  mul_p;
  logic signed [SUM_W-1:0] comb;
  logic [MAG_W-1:0]        maxv;

  rau_divider u_div (.clk_i(clk_i), .rst_ni(rst_ni), .req_i(dreq), .rsp_o(drsp));

  assign maxv = MAG_W'((64'd1 << (WORD_BITS - 1)) - 64'd1);

  always_comb begin
    mul_a = (state_q == S_MUL0) ? an_q : bn_q;
    mul_b = (state_q == S_MUL0) ? $signed({2'b00, bd_q}) : $signed({2'b00, ad_q});
    if (state_q == S_MUL0 && (op_q == OP_MUL)) mul_b = {bn_q[31], bn_q};
    if (state_q == S_MUL1 && (op_q == OP_MUL || op_q == OP_DIV)) begin
      mul_a = $signed({1'b0, ad_q});
      mul_b = (op_q == OP_MUL) ? $signed({2'b00, bd_q}) : {bn_q[31], bn_q};
    end
    if (state_q == S_MUL2) begin
      mul_a = $signed({1'b0, ad_q});
      mul_b = $signed({2'b00, bd_q});
    end
    mul_p = mul_a * mul_b;
    if (op_q == OP_SUB) comb = SUM_W'(p0_q) - SUM_W'(p1_q);
    else                comb = SUM_W'(p0_q) + SUM_W'(p1_q);
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE:      if (start) state_d = S_MUL0;
      S_MUL0:      state_d = S_MUL1;
      S_MUL1:      state_d = S_MUL2;
      S_MUL2:      state_d = S_COMB;
      S_COMB:      state_d = S_GCD_LOAD;
      S_GCD_LOAD:  state_d = (op_q > OP_CMP || ad_q == '0 || bd_q == '0 || op_q == OP_CMP ||
                              (op_q == OP_DIV && bn_q == '0) || mag_q == '0) ? S_FINISH : S_GCD;
      S_GCD:       if (drsp.done) state_d = (drsp.remainder == '0) ? S_DIVN_LOAD : S_GCD;
      S_DIVN_LOAD: state_d = S_DIVN;
      S_DIVN:      if (drsp.done) state_d = S_DIVD_LOAD;
      S_DIVD_LOAD: state_d = S_DIVD;
      S_DIVD:      if (drsp.done) state_d = S_FINISH;
      S_FINISH:    state_d = S_IDLE;
      default:     state_d = S_IDLE;
    endcase
  end

  always_comb begin
    p0_d = p0_q; p1_d = p1_q; den_d = den_q; neg_d = neg_q; mag_d = mag_q;
    u_d = u_q; v_d = v_q; done_d = 1'b0;
    rn_d = rn_q; rd_d = rd_q; gt_d = gt_q; eq_d = eq_q; st_d = st_q;
    dreq = '0;
    case (state_q)
      S_MUL0: p0_d = mul_p[PROD_W-1:0];
      S_MUL1: p1_d = mul_p[PROD_W-1:0];
      S_MUL2: den_d = mul_p[PROD_W-1:0];
      S_COMB: begin
        if (op_q == OP_MUL || op_q == OP_DIV) begin
          den_d = p1_q;
          if (op_q == OP_DIV && p1_q[PROD_W-1]) begin
            neg_d = !p0_q[PROD_W-1] && p0_q != '0;
            mag_d = p0_q[PROD_W-1] ? MAG_W'(-p0_q) : MAG_W'(p0_q);
            den_d = -p1_q;
          end else begin
            neg_d = p0_q[PROD_W-1];
            mag_d = p0_q[PROD_W-1] ? MAG_W'(-p0_q) : MAG_W'(p0_q);
          end
        end else begin
          neg_d = comb[SUM_W-1];
          mag_d = comb[SUM_W-1] ? MAG_W'(-comb) : MAG_W'(comb);
        end
        gt_d = (p0_q > p1_q);
        eq_d = (p0_q == p1_q);
      end
      S_GCD_LOAD: begin
        u_d = mag_q; v_d = den_q;
        dreq.start = 1'b1; dreq.dividend = mag_q; dreq.divisor = den_q;
      end
      S_GCD: if (drsp.done) begin
        u_d = v_q; v_d = drsp.remainder;
        if (drsp.remainder != '0) begin
          dreq.start = 1'b1; dreq.dividend = v_q; dreq.divisor = drsp.remainder;
        end
      end
      S_DIVN_LOAD: begin
        dreq.start = 1'b1; dreq.dividend = mag_q; dreq.divisor = u_q;
      end
      S_DIVN: if (drsp.done) mag_d = drsp.quotient;
      S_DIVD_LOAD: begin
        dreq.start = 1'b1; dreq.dividend = den_q; dreq.divisor = u_q;
      end
      S_DIVD: if (drsp.done) den_d = drsp.quotient;
      S_FINISH: begin
        done_d = 1'b1;
        rn_d = '0; rd_d = 31'd1; st_d = ST_OK;
        if (op_q > OP_CMP) begin
          gt_d = 1'b0; eq_d = 1'b0;
        end else if (ad_q == '0 || bd_q == '0) begin
          gt_d = 1'b0; eq_d = 1'b0; st_d = ST_DIV_ZERO;
        end else if (op_q == OP_CMP) begin
          st_d = ST_OK;
        end else begin
          gt_d = 1'b0; eq_d = 1'b0;
          if (op_q == OP_DIV && bn_q == '0) st_d = ST_DIV_ZERO;
          else if (mag_q != '0) begin
            if ((neg_q ? mag_q > maxv + 1'b1 : mag_q > maxv) || den_q > maxv) st_d = ST_OVERFLOW;
            else begin
              rn_d = neg_q ? 32'(-mag_q) : 32'(mag_q);
              rd_d = 31'(den_q);
            end
          end
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      done_q  <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == S_IDLE && start) begin
      op_q <= operation_i; an_q <= a_num_i; ad_q <= a_den_i;
      bn_q <= b_num_i; bd_q <= b_den_i;
    end
    p0_q <= p0_d; p1_q <= p1_d; den_q <= den_d; neg_q <= neg_d; mag_q <= mag_d;
    u_q <= u_d; v_q <= v_d;
    rn_q <= rn_d; rd_q <= rd_d; gt_q <= gt_d; eq_q <= eq_d; st_q <= st_d;
  end

  assign busy         = (state_q != S_IDLE);
  assign done_o       = done_q;
  assign res_num_o    = rn_q;
  assign res_den_o    = rd_q;
  assign is_greater_o = gt_q;
  assign is_equal_o   = eq_q;
  assign status_o     = st_q;

endmodule

/* rtl/rau_divider.sv */
module rau_divider import rau_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  div_req_t req_i,
  output div_rsp_t rsp_o
);

  logic [MAG_W-1:0] quo_q, quo_d, rem_q, rem_d, dvs_q, dvs_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             busy_q, busy_d, done_q, done_d;
  logic [MAG_W:0]   trial;
  logic [MAG_W:0]   shifted;

  always_comb begin
    quo_d   = quo_q;
    rem_d   = rem_q;
    dvs_d   = dvs_q;
    cnt_d   = cnt_q;
    busy_d  = busy_q;
    done_d  = 1'b0;
    shifted = {rem_q, quo_q[MAG_W-1]};
    trial   = shifted - {1'b0, dvs_q};
    if (req_i.start) begin
      quo_d  = req_i.dividend;
      rem_d  = '0;
      dvs_d  = req_i.divisor;
      cnt_d  = '0;
      busy_d = 1'b1;
    end else if (busy_q) begin
      if (!trial[MAG_W]) begin
        rem_d = trial[MAG_W-1:0];
        quo_d = {quo_q[MAG_W-2:0], 1'b1};
      end else begin
        rem_d = shifted[MAG_W-1:0];
        quo_d = {quo_q[MAG_W-2:0], 1'b0};
      end
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == CNT_W'(MAG_W - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
    dvs_q <= dvs_d;
  end

  assign rsp_o.done      = done_q;
  assign rsp_o.quotient  = quo_q;
  assign rsp_o.remainder = rem_q;

endmodule

/* rtl/rau_checker.sv */
module rau_checker import rau_pkg::*; (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        start,
  input logic        busy,
  input logic        done_o,
  input logic [30:0] res_den_o,
  input logic [1:0]  status_o,
  input logic        is_greater_o,
  input logic        is_equal_o
);

  a_start_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy |=> busy) else $error("item not taken");
  a_done_pulse: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !done_o) else $error("result held");
  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !busy) else $error("result while busy");
  a_den_pos: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> res_den_o != '0) else $error("zero denominator");
  a_flags: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !(is_greater_o && is_equal_o) && status_o != 2'd3) else $error("bad flags");

endmodule

bind rational_arithmetic_unit rau_checker u_rau_checker (
  .clk_i(clk_i), .rst_ni(rst_ni), .start(start), .busy(busy), .done_o(done_o),
  .res_den_o(res_den_o), .status_o(status_o), .is_greater_o(is_greater_o),
  .is_equal_o(is_equal_o)
);

/* bench/testbench.sv */
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import rau_pkg::*;

  localparam longint CYCLE_LIMIT = 40_000_000;

  typedef struct {
    logic signed [31:0] num;
    logic [30:0]        den;
    logic               gt;
    logic               eq;
    status_e            st;
  } fraction_t;

  logic               clk_i;
  logic               rst_ni;
  logic               start;
  logic               busy;
  logic [2:0]         operation_i;
  logic signed [31:0] a_num_i;
  logic [30:0]        a_den_i;
  logic signed [31:0] b_num_i;
  logic [30:0]        b_den_i;
  logic               done_o;
  logic signed [31:0] res_num_o;
  logic [30:0]        res_den_o;
  logic               is_greater_o;
  logic               is_equal_o;
  logic [1:0]         status_o;

  fraction_t pending_results[$];
  int        errors;
  int        items_sent;
  int        results_seen;
  int        overflow_seen;
  int        div_zero_seen;
  int        idle_pct;
  longint    cycles;

  rational_arithmetic_unit uut (
    .clk_i(clk_i), .rst_ni(rst_ni), .start(start), .busy(busy),
    .operation_i(operation_i), .a_num_i(a_num_i), .a_den_i(a_den_i),
    .b_num_i(b_num_i), .b_den_i(b_den_i), .done_o(done_o),
    .res_num_o(res_num_o), .res_den_o(res_den_o), .is_greater_o(is_greater_o),
    .is_equal_o(is_equal_o), .status_o(status_o)
  );

  always begin
    clk_i = 1'b1;
    #5;
    clk_i = 1'b0;
    #5;
  end

  function automatic longint unsigned gcd64(longint unsigned u, longint unsigned v);
    longint unsigned r;
    while (v != 0) begin
      r = u % v;
      u = v;
      v = r;
    end
    return u;
  endfunction

  function automatic fraction_t rational_result(logic [2:0] op, logic signed [31:0] an_i,
                                                logic [30:0] ad_i, logic signed [31:0] bn_i,
                                                logic [30:0] bd_i);
    fraction_t       f;
    longint          an;
    longint          ad;
    longint          bn;
    longint          bd;
    longint          num;
    longint          den;
    longint          lhs;
    longint          rhs;
    longint unsigned mag;
    longint unsigned g;
    logic            neg;
    an = an_i;
    bn = bn_i;
    ad = longint'(ad_i);
    bd = longint'(bd_i);
    f.num = 0;
    f.den = 1;
    f.gt = 1'b0;
    f.eq = 1'b0;
    f.st = ST_OK;
    if (op > OP_CMP) return f;
    if (ad == 0 || bd == 0) begin
      f.st = ST_DIV_ZERO;
      return f;
    end
    if (op == OP_CMP) begin
      lhs = an * bd;
      rhs = bn * ad;
      f.gt = lhs > rhs;
      f.eq = lhs == rhs;
      return f;
    end
    case (op_e'(op))
      OP_ADD: begin
        num = an * bd + ad * bn;
        den = ad * bd;
      end
      OP_SUB: begin
        num = an * bd - ad * bn;
        den = ad * bd;
      end
      OP_MUL: begin
        num = an * bn;
        den = ad * bd;
      end
      default: begin
        if (bn == 0) begin
          f.st = ST_DIV_ZERO;
          return f;
        end
        num = an * bd;
        den = ad * bn;
        if (den < 0) begin
          num = -num;
          den = -den;
        end
      end
    endcase
    if (num == 0) return f;
    neg = num < 0;
    mag = neg ? 64'd0 - longint'(num) : num;
    g = gcd64(mag, den);
    mag = mag / g;
    den = longint'(longint'(den) / g);
    if ((neg ? mag > 64'h8000_0000 : mag > 64'h7FFF_FFFF) || den > 64'h7FFF_FFFF) begin
      f.st = ST_OVERFLOW;
      return f;
    end
    f.num = neg ? -longint'(mag) : longint'(mag);
    f.den = den[30:0];
    return f;
  endfunction

  task automatic send_item(logic [2:0] op, logic signed [31:0] an, logic [30:0] ad,
                           logic signed [31:0] bn, logic [30:0] bd);
    if ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      repeat ($urandom_range(6, 1)) @(posedge clk_i);
    end
    start <= 1'b1;
    operation_i <= op;
    a_num_i <= an;
    a_den_i <= ad;
    b_num_i <= bn;
    b_den_i <= bd;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
    pending_results.push_back(rational_result(op, an, ad, bn, bd));
    items_sent++;
  endtask

  task automatic drain_results();
    start <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
  endtask

  always @(posedge clk_i) begin
    fraction_t e;
    if (rst_ni && done_o) begin
      results_seen++;
      if (pending_results.size() == 0) begin
        $display("%0t: result with none outstanding: %0d/%0d status %0d", $time,
                 res_num_o, res_den_o, status_o);
        errors++;
      end else begin
        e = pending_results.pop_front();
        if (e.st == ST_OVERFLOW) overflow_seen++;
        if (e.st == ST_DIV_ZERO) div_zero_seen++;
        if (res_num_o !== e.num || res_den_o !== e.den || is_greater_o !== e.gt ||
            is_equal_o !== e.eq || status_o !== e.st) begin
          $display("%0t: expected %0d/%0d gt %0b eq %0b st %0d, got %0d/%0d gt %0b eq %0b st %0d",
                   $time, e.num, e.den, e.gt, e.eq, e.st, res_num_o, res_den_o,
                   is_greater_o, is_equal_o, status_o);
          errors++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  function automatic logic signed [31:0] pick_num();
    case ($urandom_range(5))
      0, 1: return $signed($urandom_range(40)) - 20;
      2: return $signed($urandom_range(65535)) - 32768;
      3: return $urandom_range(1) ? 32'sh7FFF_FFFF : 32'sh8000_0000;
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [30:0] pick_den();
    case ($urandom_range(19))
      0: return 31'd0;
      1: return 31'h7FFF_FFFF;
      2, 3, 4, 5, 6, 7: return 31'($urandom_range(20, 1));
      8, 9, 10, 11: return 31'($urandom_range(65535, 1));
      default: return 31'($urandom);
    endcase
  endfunction

  task automatic test_corners();
    logic [2:0] op;
    for (int i = 0; i <= OP_CMP; i++) begin
      op = 3'(i);
      send_item(op, 32'sh7FFF_FFFF, 31'h7FFF_FFFF, 32'sh8000_0000, 31'd1);
      send_item(op, 32'sh8000_0000, 31'd1, 32'sh8000_0000, 31'd1);
      send_item(op, 3, 31'd4, -3, 31'd4);
    end
    send_item(OP_DIV, 5, 31'd7, 0, 31'd3);
    send_item(OP_DIV, 5, 31'd7, -2, 31'd3);
    send_item(OP_CMP, 2, 31'd4, 1, 31'd2);
    send_item(OP_SUB, 1, 31'd3, 1, 31'd3);
    send_item(OP_ADD, 1, 31'd0, 1, 31'd2);
    send_item(OP_MUL, 1, 31'd2, 1, 31'd0);
    send_item(OP_CMP, 1, 31'd0, 1, 31'd2);
    for (int i = OP_CMP + 1; i < 8; i++) begin
      op = 3'(i);
      send_item(op, -7, 31'd3, 5, 31'd9);
    end
  endtask

  task automatic test_random_mix(int count, int pct);
    logic [2:0] op;
    idle_pct = pct;
    for (int i = 0; i < count; i++) begin
      op = ($urandom_range(19) == 0) ? 3'($urandom_range(7, 5)) : 3'($urandom_range(4));
      send_item(op, pick_num(), pick_den(), pick_num(), pick_den());
    end
  endtask

  initial begin
    errors = 0;
    items_sent = 0;
    results_seen = 0;
    overflow_seen = 0;
    div_zero_seen = 0;
    cycles = 0;
    idle_pct = 14;
    rst_ni = 1'b0;
    start = 1'b0;
    operation_i = '0;
    a_num_i = '0;
    a_den_i = 31'd1;
    b_num_i = '0;
    b_den_i = 31'd1;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_corners();
    drain_results();
    test_random_mix(360, 14);
    drain_results();
    test_random_mix(360, 48);
    test_random_mix(360, 0);
    drain_results();
    repeat (100) @(posedge clk_i);
    $display("Sent %0d items over all five operations and unknown codes, %0d results checked",
             items_sent, results_seen);
    $display("Overflow results: %0d, division-by-zero results: %0d",
             overflow_seen, div_zero_seen);
    if (errors == 0 && pending_results.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

/* rational_arithmetic_unit.f */
rtl/rau_pkg.sv
rtl/rau_divider.sv
rtl/rational_arithmetic_unit.sv
rtl/rau_checker.sv
bench/testbench.sv
